### hdl/kemt_pkg.sv
`timescale 1ns / 1ps
// Shared types, constants and the event-code decoder for the key event tracker.
// Used by kemt_ctrl, kemt_dp and key_event_matrix_tracker_core; depends on nothing.
package kemt_pkg;

    localparam int MapRows = 7;
    localparam int MapCols = 8;
    localparam int MapBits = MapRows * MapCols;
    localparam int IdxW    = $clog2(MapBits);

    localparam logic CMD_EVENT  = 1'b0;
    localparam logic CMD_REPORT = 1'b1;

    typedef struct packed {
        logic            hit;
        logic            set;
        logic [IdxW-1:0] idx;
    } t_key_dec;

    typedef struct packed {
        logic apply_event;
        logic load_scan;
        logic step;
        logic emit;
        logic emit_valid;
        logic emit_last;
    } t_ctrl_cmd;

    typedef struct packed {
        logic cur_bit;
        logic rest_any;
    } t_dp_stat;

    // The key number is split into row and column by a multiply with the
    // reciprocal of ten (205 / 2048), which is exact for all seven-bit keys.
    function automatic t_key_dec f_decode(input logic [7:0] code);
        logic [6:0]  key;
        logic [14:0] prod;
        logic [3:0]  row;
        logic [6:0]  col;
        t_key_dec    d;
        key   = code[6:0] - 7'd1;
        prod  = 15'(key) * 15'd205;
        row   = prod[14:11];
        col   = key - 7'(row) * 7'd10;
        d.hit = (code[6:0] != 7'd0) && (row < 4'(MapRows)) && (col < 7'(MapCols));
        d.set = code[7];
        d.idx = {row[2:0], col[2:0]};
        return d;
    endfunction

endpackage

### hdl/kemt_ctrl.sv
`timescale 1ns / 1ps
// Controller for the key event tracker: accepts commands and sequences the map scan.
// Depends on kemt_pkg.
module kemt_ctrl
    import kemt_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      start,
    input  logic      i_cmd,
    input  t_dp_stat  i_stat,
    output logic      busy,
    output t_ctrl_cmd o_ctl
);

    localparam logic S_IDLE = 1'b0;
    localparam logic S_SCAN = 1'b1;

    logic r_state;
    logic n_state;
    logic take;

    assign busy = (r_state != S_IDLE);
    assign take = start && !busy;

    always_comb begin
        n_state = r_state;
        o_ctl   = '0;
        case (r_state)
            S_IDLE: begin
                if (take && (i_cmd == CMD_EVENT)) begin
                    o_ctl.apply_event = 1'b1;
                end
                if (take && (i_cmd == CMD_REPORT)) begin
                    o_ctl.load_scan = 1'b1;
                    n_state         = S_SCAN;
                end
            end
            S_SCAN: begin
                // An empty map shows neither a current nor a remaining bit on the
                // first scan step, which yields the single invalid result.
                o_ctl.step       = 1'b1;
                o_ctl.emit       = i_stat.cur_bit || !i_stat.rest_any;
                o_ctl.emit_valid = i_stat.cur_bit;
                o_ctl.emit_last  = !i_stat.rest_any;
                if (!i_stat.rest_any) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

endmodule

### hdl/kemt_dp.sv
`timescale 1ns / 1ps
// Datapath for the key event tracker: pressed map, scan shifter and result registers.
// Depends on kemt_pkg.
module kemt_dp
    import kemt_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  t_ctrl_cmd  i_ctl,
    input  logic [7:0] i_event_code,
    output t_dp_stat   o_stat,
    output logic       o_strobe,
    output logic [3:0] o_key_x,
    output logic [1:0] o_key_y,
    output logic       o_key_valid,
    output logic       o_last
);

    logic [MapBits-1:0] r_map;
    logic [MapBits-1:0] n_map;
    logic [MapBits-1:0] r_scan;
    logic [IdxW-1:0]    r_idx;
    logic               r_strobe;
    logic [3:0]         r_key_x;
    logic [1:0]         r_key_y;
    logic               r_key_valid;
    logic               r_last;
    t_key_dec           dec;

    assign dec = f_decode(i_event_code);

    always_comb begin
        n_map = r_map;
        if (i_ctl.apply_event && dec.hit) begin
            n_map[dec.idx] = dec.set;
        end
    end

    // The scan copy moves one position per step, so bit zero is always the
    // position named by the index counter.
    assign o_stat.cur_bit  = r_scan[0];
    assign o_stat.rest_any = |r_scan[MapBits-1:1];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_map    <= '0;
            r_strobe <= 1'b0;
        end else begin
            r_map    <= n_map;
            r_strobe <= i_ctl.emit;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.load_scan) begin
            r_scan <= r_map;
            r_idx  <= '0;
        end else if (i_ctl.step) begin
            r_scan <= {1'b0, r_scan[MapBits-1:1]};
            r_idx  <= r_idx + 1'b1;
        end
        if (i_ctl.emit) begin
            if (i_ctl.emit_valid) begin
                r_key_x <= {r_idx[5:3], r_idx[2]};
                r_key_y <= r_idx[1:0];
            end else begin
                r_key_x <= '0;
                r_key_y <= '0;
            end
            r_key_valid <= i_ctl.emit_valid;
            r_last      <= i_ctl.emit_last;
        end
    end

    assign o_strobe    = r_strobe;
    assign o_key_x     = r_key_x;
    assign o_key_y     = r_key_y;
    assign o_key_valid = r_key_valid;
    assign o_last      = r_last;

endmodule

### hdl/key_event_matrix_tracker_core.sv
`timescale 1ns / 1ps
// Key event tracker. An event command updates the 7x8 pressed map in the cycle it is
// accepted and keeps busy low. A report loads the map into the scan shifter, then scans
// it one position per cycle, ending after the last pressed key; busy is high for the scan,
// and each result goes to the output registers with o_strobe high for one cycle.
// The receiver cannot stall. Synchronous active-low reset clears the map and controller.
// Depends on kemt_pkg, kemt_ctrl and kemt_dp.
module key_event_matrix_tracker_core
    import kemt_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       start,
    output logic       busy,
    input  logic       i_cmd,
    input  logic [7:0] i_event_code,
    output logic       o_strobe,
    output logic [3:0] o_key_x,
    output logic [1:0] o_key_y,
    output logic       o_key_valid,
    output logic       o_last
);

    t_ctrl_cmd ctl;
    t_dp_stat  stat;

    kemt_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .start   (start),
        .i_cmd   (i_cmd),
        .i_stat  (stat),
        .busy    (busy),
        .o_ctl   (ctl)
    );

    kemt_dp u_dp (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_ctl        (ctl),
        .i_event_code (i_event_code),
        .o_stat       (stat),
        .o_strobe     (o_strobe),
        .o_key_x      (o_key_x),
        .o_key_y      (o_key_y),
        .o_key_valid  (o_key_valid),
        .o_last       (o_last)
    );

endmodule
